// ===== hw/rtl/psd_pkg.sv =====
// Shared widths, types and constants for the point to segment distance block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_BITS  = COORD_BITS + FRAC_BITS + 1;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int SQ_W       = 2 * COORD_BITS + 1;
	localparam int Q_W        = SQ_W + 2 * FRAC_BITS;
	localparam int NUM_W      = SQ_W + Q_W;
	localparam int RT_W       = (Q_W + 1) / 2;
	localparam int SR_W       = RT_W + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0]         dist_t;

	localparam dist_t NEAR_RESET = dist_t'(5) << FRAC_BITS;

endpackage

`default_nettype wire

// ===== hw/rtl/psd_if.sv =====
// Valid/ready stream interfaces for the query and result channels.
// Depends on psd_pkg.
`default_nettype none

interface psd_req_if;
	import psd_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		input ready);
	modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
		output ready);
endinterface

interface psd_rsp_if;
	import psd_pkg::*;
	logic  valid;
	logic  ready;
	dist_t distance;
	logic  near;
	modport source (output valid, distance, near, input ready);
	modport sink (input valid, distance, near, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/point_segment_distance.sv =====
// Top level: pipelined distance from a point to a 2D segment with near flag.
// Depends on psd_pkg and the stream interfaces in psd_if.sv.
//
//   channel   direction   handshake       content
//   req       in          valid/ready     point, segment start and end
//   rsp       out         valid/ready     distance (8 fraction bits), near
//   cfg       in          write enable    near_threshold
//
// One transaction enters per cycle while the output is not stalled. The pipeline has
// five geometry stages, one restoring divider stage per quotient bit and one
// square root stage per result bit, then the output register.
// Reset clears all valid bits and loads the threshold with 5.0.
// A stall at the output freezes the whole pipeline; nothing is dropped.
`default_nettype none

module point_segment_distance (
	input  wire             clk,
	input  wire             arst_n,
	psd_req_if.sink         req,
	psd_rsp_if.source       rsp,
	input  wire             cfg_we,
	input  psd_pkg::dist_t  cfg_wdata
);
	import psd_pkg::*;

	logic adv;
	dist_t thr_q;

	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= NEAR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Stage 1: differences.
	logic v_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, ax_s1, ay_s1, bx_s1, by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIFF_W'(req.end_x) - DIFF_W'(req.start_x);
			dy_s1 <= DIFF_W'(req.end_y) - DIFF_W'(req.start_y);
			ax_s1 <= DIFF_W'(req.point_x) - DIFF_W'(req.start_x);
			ay_s1 <= DIFF_W'(req.point_y) - DIFF_W'(req.start_y);
			bx_s1 <= DIFF_W'(req.point_x) - DIFF_W'(req.end_x);
			by_s1 <= DIFF_W'(req.point_y) - DIFF_W'(req.end_y);
		end
	end

	// Stage 2: products.
	logic v_s2;
	logic signed [PROD_W-1:0] axdx_s2, aydy_s2, axdy_s2, aydx_s2;
	logic signed [PROD_W-1:0] dxx_s2, dyy_s2, axx_s2, ayy_s2, bxx_s2, byy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			axdx_s2 <= ax_s1 * dx_s1;
			aydy_s2 <= ay_s1 * dy_s1;
			axdy_s2 <= ax_s1 * dy_s1;
			aydx_s2 <= ay_s1 * dx_s1;
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			axx_s2  <= ax_s1 * ax_s1;
			ayy_s2  <= ay_s1 * ay_s1;
			bxx_s2  <= bx_s1 * bx_s1;
			byy_s2  <= by_s1 * by_s1;
		end
	end

	// Stage 3: dot and cross products, squared lengths.
	logic v_s3;
	logic signed [SUM_W-1:0] dot_s3, crs_s3;
	logic [SUM_W-1:0] len2_w, da2_w, db2_w;
	logic [SQ_W-1:0] len2_s3, da2_s3, db2_s3;

	assign len2_w = SUM_W'(dxx_s2) + SUM_W'(dyy_s2);
	assign da2_w  = SUM_W'(axx_s2) + SUM_W'(ayy_s2);
	assign db2_w  = SUM_W'(bxx_s2) + SUM_W'(byy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s3  <= SUM_W'(axdx_s2) + SUM_W'(aydy_s2);
			crs_s3  <= SUM_W'(axdy_s2) - SUM_W'(aydx_s2);
			len2_s3 <= len2_w[SQ_W-1:0];
			da2_s3  <= da2_w[SQ_W-1:0];
			db2_s3  <= db2_w[SQ_W-1:0];
		end
	end

	// Stage 4: pick the nearest feature of the segment.
	logic v_s4, perp_s4;
	logic [SQ_W-1:0] d2_s4, cmag_s4, len2_s4;
	logic [SUM_W-1:0] cabs_w;
	logic to_start_w, to_end_w;

	assign cabs_w     = crs_s3[SUM_W-1] ? SUM_W'(-crs_s3) : SUM_W'(crs_s3);
	assign to_start_w = (len2_s3 == '0) || dot_s3[SUM_W-1];
	assign to_end_w   = dot_s3 > $signed(SUM_W'(len2_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			perp_s4 <= !to_start_w && !to_end_w;
			d2_s4   <= to_start_w ? da2_s3 : db2_s3;
			cmag_s4 <= cabs_w[SQ_W-1:0];
			len2_s4 <= len2_s3;
		end
	end

	// Stage 5: numerator and denominator of the scaled squared distance.
	logic v_s5;
	logic [NUM_W-1:0] num_w;
	logic [2*SQ_W-1:0] csq_w;
	logic [SQ_W-1:0] rem_s5, den_s5;
	logic [Q_W-1:0] nq_s5;

	assign csq_w = cmag_s4 * cmag_s4;
	assign num_w = perp_s4 ? (NUM_W'(csq_w) << (2 * FRAC_BITS))
		: (NUM_W'(d2_s4) << (2 * FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s5 <= num_w[NUM_W-1:Q_W];
			nq_s5  <= num_w[Q_W-1:0];
			den_s5 <= perp_s4 ? len2_s4 : SQ_W'(1);
		end
	end

	// Restoring divider: one quotient bit per stage; numerator bits shift out
	// at the top while quotient bits shift in at the bottom.
	logic            div_v_sn   [Q_W+1];
	logic [SQ_W-1:0] div_rem_sn [Q_W+1];
	logic [SQ_W-1:0] div_den_sn [Q_W+1];
	logic [Q_W-1:0]  div_nq_sn  [Q_W+1];

	assign div_v_sn[0]   = v_s5;
	assign div_rem_sn[0] = rem_s5;
	assign div_den_sn[0] = den_s5;
	assign div_nq_sn[0]  = nq_s5;

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		logic [SQ_W:0] t_w;
		logic ge_w;
		assign t_w  = {div_rem_sn[i], div_nq_sn[i][Q_W-1]};
		assign ge_w = t_w >= {1'b0, div_den_sn[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_sn[i+1] <= 1'b0;
			end else if (adv) begin
				div_v_sn[i+1] <= div_v_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_sn[i+1] <= ge_w ? SQ_W'(t_w - {1'b0, div_den_sn[i]}) : t_w[SQ_W-1:0];
				div_den_sn[i+1] <= div_den_sn[i];
				div_nq_sn[i+1]  <= {div_nq_sn[i][Q_W-2:0], ge_w};
			end
		end
	end

	// Integer square root: one result bit per stage.
	logic              sq_v_sn    [RT_W+1];
	logic [2*RT_W-1:0] sq_val_sn  [RT_W+1];
	logic [RT_W-1:0]   sq_root_sn [RT_W+1];
	logic [SR_W-1:0]   sq_rem_sn  [RT_W+1];

	assign sq_v_sn[0]    = div_v_sn[Q_W];
	assign sq_val_sn[0]  = (2 * RT_W)'(div_nq_sn[Q_W]);
	assign sq_root_sn[0] = '0;
	assign sq_rem_sn[0]  = '0;

	for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
		logic [SR_W-1:0] r_w, trial_w;
		logic ge_w;
		assign r_w     = {sq_rem_sn[j][SR_W-3:0], sq_val_sn[j][2*RT_W-1 -: 2]};
		assign trial_w = SR_W'({sq_root_sn[j], 2'b01});
		assign ge_w    = r_w >= trial_w;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_sn[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v_sn[j+1] <= sq_v_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_val_sn[j+1]  <= sq_val_sn[j] << 2;
				sq_rem_sn[j+1]  <= ge_w ? r_w - trial_w : r_w;
				sq_root_sn[j+1] <= {sq_root_sn[j][RT_W-2:0], ge_w};
			end
		end
	end

	// Output register.
	dist_t root_w;
	assign root_w = DIST_BITS'(sq_root_sn[RT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (adv) begin
			rsp.valid <= sq_v_sn[RT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.distance <= root_w;
			rsp.near     <= root_w <= thr_q;
		end
	end

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> den_s5 != '0)
		else $error("divider entered with zero denominator");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_sn[Q_W] |-> div_rem_sn[Q_W] < div_den_sn[Q_W])
		else $error("divider remainder not below denominator");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sq_root_sn[RT_W]) && $stable(div_nq_sn[Q_W]))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for point_segment_distance: directed table then random geometry queries,
// checked against an exact integer predictor. Depends on psd_pkg and psd_if.sv.
`timescale 1ns / 1ps

module tb_top;
	import psd_pkg::*;

	localparam int LATENCY     = 80;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam dist_t THR_MAX  = dist_t'(23726592);

	typedef struct {
		coord_t px, py, sx, sy, ex, ey;
		bit     typed;
		dist_t  dval;
		logic   near;
	} query_t;

	typedef struct {
		dist_t dval;
		logic  near;
	} answer_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	dist_t cfg_wdata = '0;

	psd_req_if req ();
	psd_rsp_if rsp ();

	point_segment_distance DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dist_t   threshold = NEAR_RESET;
	query_t  offered[$];
	answer_t awaited[$];
	int      errors = 0;
	int      sent = 0;
	int      checked = 0;
	int      idle_cycles = 0;
	bit      hold_request = 1'b0;

	function automatic dist_t floor_root(logic [127:0] scaled, logic [127:0] den);
		logic [127:0] r;
		logic [127:0] cand;
		r = '0;
		for (int k = 25; k >= 0; k--) begin
			cand = r | (128'd1 << k);
			if (cand * cand * den <= scaled)
				r = cand;
		end
		return dist_t'(r);
	endfunction

	function automatic dist_t segment_distance(query_t q);
		longint dx, dy, ax, ay, bx, by, len2, dotp, crossp;
		logic [127:0] wide;
		dx = longint'(q.ex) - longint'(q.sx);
		dy = longint'(q.ey) - longint'(q.sy);
		ax = longint'(q.px) - longint'(q.sx);
		ay = longint'(q.py) - longint'(q.sy);
		bx = longint'(q.px) - longint'(q.ex);
		by = longint'(q.py) - longint'(q.ey);
		len2 = dx * dx + dy * dy;
		dotp = ax * dx + ay * dy;
		if (len2 == 0 || dotp < 0)
			return floor_root(128'(ax * ax + ay * ay) << 2 * FRAC_BITS, 128'd1);
		if (dotp > len2)
			return floor_root(128'(bx * bx + by * by) << 2 * FRAC_BITS, 128'd1);
		crossp = ax * dy - ay * dx;
		if (crossp < 0)
			crossp = -crossp;
		wide = 128'(crossp);
		return floor_root((wide * wide) << 2 * FRAC_BITS, 128'(len2));
	endfunction

	task automatic report(string what, dist_t got_d, logic got_n, answer_t want);
		errors++;
		$display("mismatch %s: distance %0d near %0b, expected %0d near %0b", what,
			got_d, got_n, want.dval, want.near);
	endtask

	always @(posedge clk) begin
		query_t  q;
		answer_t a;
		if (req.valid && req.ready) begin
			q = offered.pop_front();
			a.dval = q.typed ? q.dval : segment_distance(q);
			a.near = q.typed ? q.near : (a.dval <= threshold);
			awaited.push_back(a);
		end
		if (rsp.valid && rsp.ready) begin
			if (awaited.size() == 0) begin
				a.dval = 'x;
				a.near = 'x;
				report("unexpected transaction", rsp.distance, rsp.near, a);
			end else begin
				a = awaited.pop_front();
				checked++;
				if (rsp.distance !== a.dval)
					report("distance", rsp.distance, rsp.near, a);
				else if (rsp.near !== a.near)
					report("near flag", rsp.distance, rsp.near, a);
			end
		end
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d transactions outstanding", awaited.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: switches between randomly chosen stall patterns, with a single long hold when the test requests it.
	initial begin
		int mode;
		int count;
		rsp.ready <= 1'b0;
		mode = 0;
		count = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			if (count % 64 == 0)
				mode = $urandom_range(0, 3);
			count++;
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 9) < 7);
				2: rsp.ready <= (count % 3 != 0);
				default: rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic coord_t pick_coord(int style);
		case (style)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 40) - 20);
			default: return $urandom_range(0, 1) ? coord_t'(16'h7fff) : coord_t'(16'h8000);
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int style;
		style = $urandom_range(0, 9);
		style = style < 5 ? 0 : (style < 9 ? 1 : 2);
		q.px = pick_coord(style);
		q.py = pick_coord(style);
		q.sx = pick_coord(style);
		q.sy = pick_coord(style);
		if ($urandom_range(0, 9) == 0) begin
			q.ex = q.sx;
			q.ey = q.sy;
		end else begin
			q.ex = pick_coord(style);
			q.ey = pick_coord(style);
		end
		q.typed = 1'b0;
		q.dval = '0;
		q.near = 1'b0;
		return q;
	endfunction

	task automatic offer(query_t q);
		offered.push_back(q);
		req.valid <= 1'b1;
		req.point_x <= q.px;
		req.point_y <= q.py;
		req.start_x <= q.sx;
		req.start_y <= q.sy;
		req.end_x <= q.ex;
		req.end_y <= q.ey;
		do
			@(posedge clk);
		while (!req.ready);
		sent++;
	endtask

	task automatic random_burst_run(int count);
		int burst;
		int gap;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			for (int i = 0; i < burst && count > 0; i++, count--)
				offer(random_query());
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid <= 1'b0;
	endtask

	task automatic drain_and_write(dist_t value);
		while (awaited.size() != 0 || offered.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		threshold = value;
		cfg_we <= 1'b0;
	endtask

	function automatic query_t row(int px, int py, int sx, int sy, int ex, int ey,
		bit typed = 1'b0, int d = 0, bit n = 1'b0);
		query_t q;
		q.px = coord_t'(px);
		q.py = coord_t'(py);
		q.sx = coord_t'(sx);
		q.sy = coord_t'(sy);
		q.ex = coord_t'(ex);
		q.ey = coord_t'(ey);
		q.typed = typed;
		q.dval = dist_t'(d);
		q.near = n;
		return q;
	endfunction

	initial begin
		query_t directed[$];
		req.valid <= 1'b0;
		req.point_x <= '0;
		req.point_y <= '0;
		req.start_x <= '0;
		req.start_y <= '0;
		req.end_x <= '0;
		req.end_y <= '0;

		// Zero-length segments, clamps at both ends, perpendicular feet and extremes.
		directed.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 1));
		directed.push_back(row(3, 4, 0, 0, 0, 0, 1, 1280, 1));
		directed.push_back(row(3, 5, 0, 0, 0, 0));
		directed.push_back(row(-3, -4, 0, 0, 10, 0, 1, 1280, 1));
		directed.push_back(row(13, 4, 0, 0, 10, 0, 1, 1280, 1));
		directed.push_back(row(0, 10, -5, 0, 5, 0, 1, 2560, 0));
		directed.push_back(row(10, 7, 0, 0, 10, 0, 1, 1792, 0));
		directed.push_back(row(0, 7, 0, 0, 10, 0, 1, 1792, 0));
		directed.push_back(row(5, 1, 0, 0, 10, 0, 1, 256, 1));
		directed.push_back(row(1, 0, 0, 0, 2, 2));
		directed.push_back(row(32767, 32767, -32768, -32768, -32768, -32768));
		directed.push_back(row(-32768, -32768, 32767, 32767, 32767, 32767));
		directed.push_back(row(32767, -32768, -32768, 32767, -32768, 32767));
		directed.push_back(row(-32768, 32767, -32768, -32768, 32767, 32767));
		directed.push_back(row(32767, -32768, -32768, -32768, 32767, 32767));
		directed.push_back(row(-32768, 32767, 32767, -32768, -32768, -32768));
		directed.push_back(row(0, 32767, -32768, -32768, 32767, -32768));
		directed.push_back(row(7, 3, 1, 1, 12, 9));
		directed.push_back(row(-1, -1, -32768, 32767, 32767, -32768));
		directed.push_back(row(100, -200, -7, 3, 55, -91));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i]);
		req.valid <= 1'b0;

		drain_and_write(dist_t'(0));
		random_burst_run(210);
		drain_and_write(THR_MAX);
		random_burst_run(210);
		drain_and_write(dist_t'($urandom_range(0, 20000)));
		hold_request = 1'b1;
		random_burst_run(210);
		drain_and_write(dist_t'($urandom_range(0, 23726592)));
		random_burst_run(210);
		drain_and_write(dist_t'(1280));
		random_burst_run(210);

		while (awaited.size() != 0 || offered.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d queries sent, %0d results checked over five near thresholds",
			sent, checked);
		$display("including zero, the largest distance and a long output stall");
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/psd_pkg.sv
hw/rtl/psd_if.sv
hw/rtl/point_segment_distance.sv
verif/tb_top.sv
